// File: rtl/shamh_pkg.sv
// shared types, round constants and sha-256 mixing functions
// used by shamh_front, shamh_core and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shamh_pkg;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  // one classified request from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } cmd_t;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_message_hash_top.sv
// top level of the sha-256 message hash: front queue plus hashing back end
// depends on shamh_pkg, shamh_front, shamh_core
//
//  channel   direction  handshake               payload
//  input     in         push / full             data_byte[7:0], no_byte, last
//  result    out        empty / pop             digest_part[63:0], part_last
//
// the back end takes a message byte at a time while idle; the 64th byte of a block
// also starts a compression (load, 64 rounds on the single round unit, chain add)
// a last item pads one byte per cycle up to the end of the block, then one or
// two compressions, then four digest parts; a 4-entry request queue lets the
// input keep going while the back end compresses
// a stalled result holds in the digest register; the back end waits only when
// a new digest is ready and the previous one is not fully taken
// reset is synchronous and active high and clears all control state at once
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hash_top
  import shamh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        no_byte,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      digest_part,
  output logic             part_last
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  shamh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .no_byte   (no_byte),
    .last      (last),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  shamh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .digest_part (digest_part),
    .part_last   (part_last)
  );

endmodule

`default_nettype wire

// File: rtl/shamh_front.sv
// front end: takes input items, drops the ones that do nothing, queues requests
// depends on shamh_pkg
`timescale 1ns / 1ps
`default_nettype none

module shamh_front
  import shamh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       no_byte,
  input  wire logic       last,
  output cmd_t            cmd,
  output logic            cmd_valid,
  input  wire logic       cmd_take
);

  cmd_t               queue [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               wr;
  logic               rd;

  assign full      = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // an item with no byte that does not end the message changes nothing
  assign wr = push && !full && (!no_byte || last);
  assign rd = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      queue[wr_ptr] <= '{data: data_byte, has_byte: !no_byte, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
    else $error("request queue count beyond depth");

  a_count_drain: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> (count == $past(count) - 1'b1))
    else $error("request queue count did not drop on take");

endmodule

`default_nettype wire

// File: rtl/shamh_core.sv
// back end: block buffer, padding sequencer, one sha-256 round per cycle,
// digest output register; depends on shamh_pkg
`timescale 1ns / 1ps
`default_nettype none

module shamh_core
  import shamh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_take,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      digest_part,
  output logic             part_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]   state;
  logic [5:0]   pos;
  logic [5:0]   round;
  logic [60:0]  byte_cnt;
  logic         pad_active;
  logic         pad_first;
  logic         len_mode;
  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [255:0] out_digest;
  logic [2:0]   out_count;

  logic         take;
  logic         append_en;
  logic [7:0]   append_byte;
  logic [7:0]   pad_byte;
  logic [63:0]  bit_count;
  logic [63:0]  len_shift;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign take     = (state == S_IDLE) && cmd_valid;
  assign cmd_take = take;

  // length bytes go out most significant first at positions 56..63
  assign bit_count = {byte_cnt, 3'b000};
  assign len_shift = bit_count << {pos[2:0], 3'b000};
  assign pad_byte  = pad_first ? PAD_MARK :
                     ((len_mode || pos == LEN_POS) ? len_shift[63:56] : 8'h00);

  assign append_en   = (take && cmd.has_byte) || (state == S_PAD);
  assign append_byte = (state == S_PAD) ? pad_byte : cmd.data;

  // schedule runs in place: w[0] is the word for this round
  assign w_new = w[0] + small_sig0(w[1]) + w[9] + small_sig1(w[14]);
  assign t1    = v[7] + big_sig1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[round] + w[0];
  assign t2    = big_sig0(v[0]) + majority(v[0], v[1], v[2]);

  assign empty       = (out_count == 3'd0);
  assign digest_part = out_digest[255:192];
  assign part_last   = (out_count == 3'd1);

  always_ff @(posedge clk) begin
    if (append_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], append_byte};
    end else if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      v <= chain;
    end else if (state == S_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      round      <= '0;
      byte_cnt   <= '0;
      pad_active <= 1'b0;
      pad_first  <= 1'b0;
      len_mode   <= 1'b0;
      out_count  <= '0;
      chain      <= HASH_IV;
    end else begin
      if (append_en) begin
        pos <= pos + 1'b1;
      end
      if (pop && !empty) begin
        out_digest <= {out_digest[191:0], 64'h0};
        out_count  <= out_count - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (cmd.has_byte) begin
              byte_cnt <= byte_cnt + 61'd1;
            end
            pad_active <= cmd.last;
            pad_first  <= 1'b1;
            len_mode   <= 1'b0;
            if (cmd.has_byte && pos == LAST_POS) begin
              state <= S_INIT;
            end else if (cmd.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (!pad_first && pos == LEN_POS) begin
            len_mode <= 1'b1;
          end
          if (pos == LAST_POS) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          if (len_mode) begin
            state <= S_OUT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          // wait until the previous digest has been fully taken
          if (empty) begin
            for (int i = 0; i < 8; i++) begin
              out_digest[255 - 32*i -: 32] <= chain[i];
            end
            out_count  <= 3'd4;
            chain      <= HASH_IV;
            byte_cnt   <= '0;
            pad_active <= 1'b0;
            len_mode   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (round == 6'd0))
    else $error("round counter not zero outside compression");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> (state == S_ADD))
    else $error("compression did not end after 64 rounds");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= 3'd4)
    else $error("digest part count beyond four");

  a_digest_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && empty) |=> (out_count == 3'd4 && byte_cnt == '0 && state == S_IDLE))
    else $error("digest load did not restart the message");

endmodule

`default_nettype wire

// File: dv/sha256_message_hash_checker.sv
// checker for the sha-256 message hash: watches the request and result queues,
// predicts the four digest parts of each message and compares them in order
// standalone, no package dependencies
`timescale 1ns / 1ps

module sha256_message_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        no_byte,
  input  logic        last,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] digest_part,
  input  logic        part_last,
  output int          fail_count,
  output int          parts_waiting
);

  typedef struct {
    logic [63:0] part;
    logic        is_last;
  } digest_slice_t;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_WORDS [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]   hash_h [8];
  logic [31:0]   blk_w [16];
  logic [63:0]   bit_len;
  digest_slice_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    int sh;
    sh = (3 - pos[1:0]) * 8;
    blk_w[pos[5:2]] = (blk_w[pos[5:2]] & ~(32'hff << sh)) | ({24'h0, b} << sh);
  endfunction

  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wi, t1, t2, x15, x2;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        // message schedule kept in a rolling 16-word window
        x15 = w[(i - 15) & 15];
        x2  = w[(i - 2) & 15];
        wi  = w[i & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w[(i - 7) & 15]
              + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        w[i & 15] = wi;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_WORDS[i] + wi;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endfunction

  function automatic void absorb_request(input logic [7:0] b, input logic nb, input logic lst);
    logic [5:0]    pos;
    digest_slice_t s;
    if (!nb) begin
      pos = bit_len[8:3];
      place_byte(pos, b);
      bit_len = bit_len + 64'd8;
      if (pos == 6'd63) fold_block();
    end
    if (lst) begin
      pos = bit_len[8:3];
      place_byte(pos, 8'h80);
      for (int k = pos + 1; k < 64; k++) place_byte(6'(k), 8'h00);
      // no room left for the length: it goes into an extra block
      if (pos >= 6'd56) begin
        fold_block();
        for (int i = 0; i < 16; i++) blk_w[i] = 32'h0;
      end
      blk_w[14] = bit_len[63:32];
      blk_w[15] = bit_len[31:0];
      fold_block();
      for (int k = 0; k < 4; k++) begin
        s.part    = {hash_h[2 * k], hash_h[2 * k + 1]};
        s.is_last = (k == 3);
        digest_q.insert(digest_q.size(), s);
      end
      for (int i = 0; i < 8; i++) hash_h[i] = IV_WORDS[i];
      bit_len = 64'd0;
    end
  endfunction

  initial begin
    fail_count    = 0;
    parts_waiting = 0;
    bit_len       = 64'd0;
    for (int i = 0; i < 8; i++) hash_h[i] = IV_WORDS[i];
  end

  always @(posedge clk) begin
    digest_slice_t exp_s;
    if (rst) begin
      for (int i = 0; i < 8; i++) hash_h[i] = IV_WORDS[i];
      bit_len = 64'd0;
      digest_q.delete();
    end else begin
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          $error("digest part with no request pending: digest_part %h part_last %b",
                 digest_part, part_last);
          fail_count++;
        end else begin
          exp_s = digest_q.pop_front();
          if (digest_part !== exp_s.part) begin
            $error("digest_part expected %h actual %h", exp_s.part, digest_part);
            fail_count++;
          end
          if (part_last !== exp_s.is_last) begin
            $error("part_last expected %b actual %b", exp_s.is_last, part_last);
            fail_count++;
          end
        end
      end
      if (push && !full) absorb_request(data_byte, no_byte, last);
    end
    parts_waiting <= digest_q.size();
  end

endmodule

// File: dv/sha256_message_hash_top_tb.sv
// testbench top for the sha-256 message hash: drives message bytes in bursts,
// pops digest parts with random stalls and one long hold-off, gives the verdict
// depends on sha256_message_hash_top and sha256_message_hash_checker
`timescale 1ns / 1ps

module sha256_message_hash_top_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        no_byte = 1'b0;
  logic        last = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [63:0] digest_part;
  logic        part_last;
  int          fail_count;
  int          parts_waiting;

  int          burst_left = 1;
  int          msg_items = 0;

  always #4 clk = ~clk;

  sha256_message_hash_top uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .no_byte     (no_byte),
    .last        (last),
    .empty       (empty),
    .pop         (pop),
    .digest_part (digest_part),
    .part_last   (part_last)
  );

  sha256_message_hash_checker chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .no_byte       (no_byte),
    .last          (last),
    .empty         (empty),
    .pop           (pop),
    .digest_part   (digest_part),
    .part_last     (part_last),
    .fail_count    (fail_count),
    .parts_waiting (parts_waiting)
  );

  // offer one request and hold it until accepted, then maybe open a gap
  task automatic send_req(input logic [7:0] b, input logic nb, input logic lst);
    push      <= 1'b1;
    data_byte <= b;
    no_byte   <= nb;
    last      <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    msg_items++;
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // len bytes of random content; the end mark rides on the final byte or on
  // a trailing request with no byte; stray no-byte requests are mixed in
  task automatic send_message(input int len, input bit mark_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(8'($urandom), 1'b1, 1'b0);
      send_req(8'($urandom), 1'b0, (mark_on_byte && i == len - 1));
    end
    if (!mark_on_byte || len == 0) begin
      send_req(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  initial begin
    int lens [10];
    int len;
    lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty message, twice with different ignored data
    send_req(8'hff, 1'b1, 1'b1);
    send_req(8'h00, 1'b1, 1'b1);
    // "abc" with the end mark on the final byte
    send_req(8'h61, 1'b0, 1'b0);
    send_req(8'h62, 1'b0, 1'b0);
    send_req(8'h63, 1'b0, 1'b1);
    // extreme bytes, a stray no-byte request, end mark without a byte
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'hff, 1'b0, 1'b0);
    send_req(8'h5a, 1'b1, 1'b0);
    send_req(8'ha5, 1'b1, 1'b1);
    // one-byte messages
    send_req(8'hff, 1'b0, 1'b1);
    send_req(8'h00, 1'b0, 1'b1);
    // a stray request first, then a short message
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'h80, 1'b0, 1'b0);
    send_req(8'h7f, 1'b0, 1'b0);
    send_req(8'h01, 1'b1, 1'b1);

    while (msg_items < 270) begin
      if ($urandom_range(0, 9) < 6) len = $urandom_range(0, 12);
      else len = lens[$urandom_range(0, 9)];
      if (len > 270 - msg_items) len = 270 - msg_items;
      send_message(len, ($urandom_range(0, 1) == 1));
    end

    push <= 1'b0;
    @(posedge clk);
    while (parts_waiting != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha256_message_hash_top_tb OK");
    end else begin
      $display("sha256_message_hash_top_tb NOT OK");
    end
    $finish;
  end

  // result side: random stall phases, plus one long hold-off that backs up
  // the block while the sender keeps offering requests
  initial begin
    int  phase_left;
    int  mode;
    int  taken;
    bit  held;
    phase_left = 0;
    mode       = 0;
    taken      = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) taken++;
      if (!held && taken >= 8) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (900) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(1, 40);
        end
        phase_left--;
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            pop <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("sha256_message_hash_top_tb NOT OK");
    $finish;
  end

endmodule
